### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, masked while in reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
// next-cycle implication, masked while in reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
// condition that must hold in the cycle after reset is seen
`define ASSERT_AFTER_RESET(label, clk, rst, b) \
  label: assert property (@(posedge clk) (rst) |=> (b)) \
    else $error("post-reset check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`define ASSERT_AFTER_RESET(label, clk, rst, b)
`endif
`endif

### rtl/alc_pkg.sv
// types, constants and the ratio power function for the lux calculator
package alc_pkg;

  localparam int CH_W        = 16;
  localparam int REM_W       = CH_W + 1;
  localparam int LUX_W       = 28;
  localparam int REGION_W    = 3;
  localparam int V_W         = 31;
  localparam int C36_W       = 31;
  localparam int COEF_W      = 15;
  localparam int POW_W       = 16;
  localparam int SUB_W       = 32;
  localparam int PROD1_W     = CH_W + C36_W;
  localparam int TS_W        = 21;
  localparam int KG_W        = TS_W + 4;
  localparam int IT_W        = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_GAIN        = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRATION_TIME = 1'd1;

  // integration time codes
  localparam logic [IT_W-1:0] IT_13MS  = 2'd0;
  localparam logic [IT_W-1:0] IT_101MS = 2'd1;
  localparam logic [IT_W-1:0] IT_402MS = 2'd2;

  // time scale, q16
  localparam logic [TS_W-1:0] TS_13MS  = 21'd1927529;
  localparam logic [TS_W-1:0] TS_101MS = 21'd260063;
  localparam logic [TS_W-1:0] TS_402MS = 21'd65536;

  // q20 coefficients, BASE_LOW in q36
  localparam logic [C36_W-1:0]  BASE_LOW   = 31'd2089091072;
  localparam logic [POW_W-1:0]  COEF_LOW_B = 16'd65012;
  localparam logic [COEF_W-1:0] COEF_MID_A = 15'd23488;
  localparam logic [COEF_W-1:0] COEF_MID_B = 15'd32506;
  localparam logic [COEF_W-1:0] COEF_HI_A  = 15'd13422;
  localparam logic [COEF_W-1:0] COEF_HI_B  = 15'd16043;
  localparam logic [COEF_W-1:0] COEF_TOP_A = 15'd1531;
  localparam logic [COEF_W-1:0] COEF_TOP_B = 15'd1174;

  typedef enum logic [REGION_W-1:0] {
    REGION_DARK = 3'd0,
    REGION_LOW  = 3'd1,
    REGION_MID  = 3'd2,
    REGION_HIGH = 3'd3,
    REGION_TOP  = 3'd4,
    REGION_OVER = 3'd5
  } region_t;

  typedef struct packed {
    logic [CH_W-1:0] broadband_count;
    logic [CH_W-1:0] infrared_count;
  } alc_in_t;

  typedef struct packed {
    logic [LUX_W-1:0]    lux_value;
    logic [REGION_W-1:0] formula_region;
  } alc_out_t;

  // data that rides along the divider stages
  typedef struct packed {
    logic [CH_W-1:0] ch0;
    region_t         region;
    logic [V_W-1:0]  v_lin;
  } alc_side_t;

  // d^1.4 in q16 for table index idx, evaluated at elaboration
  function automatic logic [POW_W-1:0] pow14_entry(input int unsigned idx,
                                                   input int unsigned tbits);
    longint unsigned target;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned e;
    target = (64'(idx) * 64'(idx)) << (60 - 2 * tbits);
    lo = 0;
    hi = 4095;
    // integer fifth root of target, twelve halvings cover 0..4095
    for (int n = 0; n < 12; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        p = mid * mid * mid * mid * mid;
        if (p <= target) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    e = (64'(idx) * lo) >> (tbits - 4);
    return e[POW_W-1:0];
  endfunction

endpackage

### rtl/alc_div_stage.sv
// one restoring division step of the ratio index pipeline
module alc_div_stage
  import alc_pkg::*;
#(
  parameter int QUO_W = 8,
  parameter int QBIT  = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [REM_W-1:0] rem_in,
  input  logic [QUO_W-1:0] quo_in,
  input  alc_side_t        side_in,
  output logic             valid_out,
  output logic [REM_W-1:0] rem_out,
  output logic [QUO_W-1:0] quo_out,
  output alc_side_t        side_out
);

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_next;
  logic [QUO_W-1:0] quo_next;

  always_comb begin
    trial = {rem_in, 1'b0};
    diff  = trial - {2'b00, side_in.ch0};
    ge    = trial >= {2'b00, side_in.ch0};
    rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    quo_next = quo_in;
    quo_next[QBIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      quo_out  <= quo_next;
      side_out <= side_in;
    end
  end

endmodule

### rtl/alc_pow_rom.sv
// d^1.4 lookup table with registered read
module alc_pow_rom
  import alc_pkg::*;
#(
  parameter int RATIO_TABLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [RATIO_TABLE_BITS-1:0] addr,
  output logic [POW_W-1:0]            data_q
);

  localparam int DEPTH = 2 ** RATIO_TABLE_BITS;

  logic [POW_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [POW_W-1:0] ENTRY = pow14_entry(g, RATIO_TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_q <= rom[addr];
    end
  end

endmodule

### rtl/alc_scale.sv
// gain and integration scaling, q.8 alignment and saturation
module alc_scale
  import alc_pkg::*;
#(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  logic [V_W-1:0]  v_in,
  input  region_t         region_in,
  input  logic [KG_W-1:0] scale_in,
  output logic            out_valid,
  output alc_out_t        out_data
);

  localparam int PROD_W = V_W + KG_W;
  localparam int SHIFT  = 36 - LUX_FRAC_BITS;

  logic              prod_valid;
  logic [PROD_W-1:0] prod_q;
  region_t           prod_region;
  logic [PROD_W-1:0] shifted;
  logic              sat;
  logic [LUX_W-1:0]  lux;

  always_comb begin
    shifted = prod_q >> SHIFT;
    sat     = |shifted[PROD_W-1:LUX_W];
    lux     = sat ? {LUX_W{1'b1}} : shifted[LUX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= valid_in;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q      <= PROD_W'(v_in) * PROD_W'(scale_in);
      prod_region <= region_in;
      out_data.lux_value      <= lux;
      out_data.formula_region <= prod_region;
    end
  end

endmodule

### rtl/ambient_light_lux_calc.sv
// two-channel light count to lux converter, top level
//
// channel  dir  handshake               contents
// in       in   in_valid / in_ready     in_data: broadband_count, infrared_count
// out      out  out_valid / out_ready   out_data: lux_value, formula_region
// cfg      in   cfg_write_en            cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ready is high
// the pipeline runs through the ratio divider (one quotient bit per stage) and the
// lookup, multiply and subtract chain of the lowest ratio region
// rst is synchronous: clears all stage valids and loads the config defaults
// out_valid with out_ready low freezes every stage and drops in_ready
`include "assert_macros.svh"
module ambient_light_lux_calc
  import alc_pkg::*;
#(
  parameter int RATIO_TABLE_BITS = 8,
  parameter int LUX_FRAC_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  alc_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output alc_out_t               out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NDIV = RATIO_TABLE_BITS;

  logic            adv;
  logic            high_gain;
  logic [IT_W-1:0] integration_time;
  logic [TS_W-1:0] time_scale;
  logic [KG_W-1:0] scale;

  // front stages
  logic [CH_W-1:0] ch0_in;
  logic [CH_W-1:0] ch1_in;
  region_t         region_in;
  logic            s1_valid;
  logic [CH_W-1:0] s1_ch0;
  logic [CH_W-1:0] s1_ch1;
  region_t         s1_region;
  logic [COEF_W-1:0] coef_a;
  logic [COEF_W-1:0] coef_b;
  logic            s2_valid;
  logic [CH_W-1:0] s2_ch0;
  logic [CH_W-1:0] s2_ch1;
  region_t         s2_region;
  logic [V_W-1:0]  s2_pos;
  logic [V_W-1:0]  s2_neg;
  logic            s3_valid;
  logic [CH_W-1:0] s3_ch1;
  alc_side_t       s3_side;

  // divider chain
  logic             div_valid [NDIV+1];
  logic [REM_W-1:0] div_rem   [NDIV+1];
  logic [NDIV-1:0]  div_quo   [NDIV+1];
  alc_side_t        div_side  [NDIV+1];

  // low region chain
  logic              r_valid;
  alc_side_t         r_side;
  logic [POW_W-1:0]  pow_q;
  logic              b_valid;
  alc_side_t         b_side;
  logic [SUB_W-1:0]  b_sub;
  logic              c_valid;
  alc_side_t         c_side;
  logic [C36_W-1:0]  c_c36;
  logic              p_valid;
  alc_side_t         p_side;
  logic [PROD1_W-1:0] p_prod;
  logic              v_valid;
  logic [V_W-1:0]    v_value;
  region_t           v_region;

  // whole pipe moves together; the output stage is the only one that can block
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_gain        <= 1'b1;
      integration_time <= IT_13MS;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_HIGH_GAIN:        high_gain <= cfg_data[0];
        REG_INTEGRATION_TIME: integration_time <= cfg_data;
      endcase
    end
  end

  always_comb begin
    unique case (integration_time)
      IT_13MS:  time_scale = TS_13MS;
      IT_101MS: time_scale = TS_101MS;
      default:  time_scale = TS_402MS;
    endcase
    // low gain multiplies by 16
    scale = high_gain ? {4'b0000, time_scale} : {time_scale, 4'b0000};
  end

  // ratio region from exact integer compares
  always_comb begin
    ch0_in = in_data.broadband_count;
    ch1_in = in_data.infrared_count;
    priority if (ch0_in == '0) begin
      region_in = REGION_DARK;
    end else if ({ch1_in, 1'b0} <= {1'b0, ch0_in}) begin
      region_in = REGION_LOW;
    end else if (23'(ch1_in) * 23'd100 <= 23'(ch0_in) * 23'd61) begin
      region_in = REGION_MID;
    end else if (19'(ch1_in) * 19'd5 <= 19'(ch0_in) * 19'd4) begin
      region_in = REGION_HIGH;
    end else if (20'(ch1_in) * 20'd10 <= 20'(ch0_in) * 20'd13) begin
      region_in = REGION_TOP;
    end else begin
      region_in = REGION_OVER;
    end
  end

  always_comb begin
    unique case (s1_region)
      REGION_MID: begin
        coef_a = COEF_MID_A;
        coef_b = COEF_MID_B;
      end
      REGION_HIGH: begin
        coef_a = COEF_HI_A;
        coef_b = COEF_HI_B;
      end
      REGION_TOP: begin
        coef_a = COEF_TOP_A;
        coef_b = COEF_TOP_B;
      end
      default: begin
        coef_a = '0;
        coef_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch0    <= ch0_in;
      s1_ch1    <= ch1_in;
      s1_region <= region_in;
      s2_ch0    <= s1_ch0;
      s2_ch1    <= s1_ch1;
      s2_region <= s1_region;
      s2_pos    <= V_W'(coef_a) * V_W'(s1_ch0);
      s2_neg    <= V_W'(coef_b) * V_W'(s1_ch1);
      s3_ch1         <= s2_ch1;
      s3_side.ch0    <= s2_ch0;
      s3_side.region <= s2_region;
      s3_side.v_lin  <= (s2_pos > s2_neg) ? s2_pos - s2_neg : '0;
    end
  end

  // index = floor(ch1 * 2^bits / ch0), valid in the low region where 2*ch1 <= ch0
  assign div_valid[0] = s3_valid;
  assign div_rem[0]   = {1'b0, s3_ch1};
  assign div_quo[0]   = '0;
  assign div_side[0]  = s3_side;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    alc_div_stage #(
      .QUO_W (NDIV),
      .QBIT  (NDIV - 1 - g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (div_valid[g]),
      .rem_in    (div_rem[g]),
      .quo_in    (div_quo[g]),
      .side_in   (div_side[g]),
      .valid_out (div_valid[g+1]),
      .rem_out   (div_rem[g+1]),
      .quo_out   (div_quo[g+1]),
      .side_out  (div_side[g+1])
    );
  end

  alc_pow_rom #(
    .RATIO_TABLE_BITS (RATIO_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (adv),
    .addr   (div_quo[NDIV]),
    .data_q (pow_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      p_valid <= 1'b0;
      v_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= div_valid[NDIV];
      b_valid <= r_valid;
      c_valid <= b_valid;
      p_valid <= c_valid;
      v_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_side <= div_side[NDIV];
      b_side <= r_side;
      b_sub  <= SUB_W'(COEF_LOW_B) * SUB_W'(pow_q);
      c_side <= b_side;
      c_c36  <= ({1'b0, BASE_LOW} > b_sub) ? C36_W'({1'b0, BASE_LOW} - b_sub) : '0;
      p_side <= c_side;
      p_prod <= PROD1_W'(c_side.ch0) * PROD1_W'(c_c36);
      v_region <= p_side.region;
      v_value  <= (p_side.region == REGION_LOW) ? p_prod[PROD1_W-1:16] : p_side.v_lin;
    end
  end

  alc_scale #(
    .LUX_FRAC_BITS (LUX_FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (v_valid),
    .v_in      (v_value),
    .region_in (v_region),
    .scale_in  (scale),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `ASSERT_IMPLY(a_dark_zero, clk, rst, out_valid && out_data.formula_region == REGION_DARK, out_data.lux_value == '0)
  `ASSERT_IMPLY(a_over_zero, clk, rst, out_valid && out_data.formula_region == REGION_OVER, out_data.lux_value == '0)
  `ASSERT_NEXT(a_stall_keeps, clk, rst, out_valid && !out_ready && v_valid, v_valid && out_valid)
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !out_valid && !v_valid)

endmodule
